FILE: hdl/slbg_pkg.sv
package slbg_pkg;

    localparam int SEGMENT_COUNT = 12;

    localparam int SPEED_W = 16;
    localparam int TIME_W  = 32;
    localparam int OUT_W   = 12;

    // quotient bits per divider, dividend width, segment count width
    localparam int QUO_W = $clog2(SEGMENT_COUNT);
    localparam int DIV_W = SPEED_W + QUO_W;
    localparam int CNT_W = $clog2(SEGMENT_COUNT + 1);

    // flash phase: even 125 ms phases lit, found from time_ms mod 250
    localparam int PHASE_MS     = 125;
    localparam int PHASE_PERIOD = 2 * PHASE_MS;
    localparam int POW8_MOD     = 256 % PHASE_PERIOD;
    localparam int POW16_MOD    = 65536 % PHASE_PERIOD;
    localparam int POW24_MOD    = (POW16_MOD * POW8_MOD) % PHASE_PERIOD;
    localparam int TRES_W       = 17;
    localparam int FOLD2_W      = 11;
    localparam int FOLD3_W      = 9;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_START_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED_THRESHOLD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_THRESHOLD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_ENABLE    = 3'd4;

    typedef struct packed {
        logic [SPEED_W-1:0] start_threshold;
        logic [SPEED_W-1:0] red_threshold;
        logic [SPEED_W-1:0] flash_threshold;
        logic [SPEED_W-1:0] full_threshold;
        logic               flash_enable;
    } slbg_cfg_t;

    // one request on its way through the divider chain
    typedef struct packed {
        logic               active;   // valid sample and ordered thresholds
        logic               flash;    // flash mode applies
        logic               at_full;  // speed >= full threshold
        logic               below;    // speed < start threshold
        logic [DIV_W-1:0]   rem_c;    // bar count remainder
        logic [DIV_W-1:0]   rem_r;    // red index remainder
        logic [DIV_W-1:0]   divisor;  // range, pre-shifted for the current cell
        logic [QUO_W-1:0]   q_c;
        logic [QUO_W-1:0]   q_r;
        logic [TRES_W-1:0]  t_res;    // partly reduced time_ms mod 250
    } slbg_work_t;

endpackage

FILE: hdl/slbg_in_if.sv
interface slbg_in_if
    import slbg_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] engine_speed;
    logic               speed_valid;
    logic [TIME_W-1:0]  time_ms;

    modport source (
        output valid, engine_speed, speed_valid, time_ms,
        input  ready
    );

    modport sink (
        input  valid, engine_speed, speed_valid, time_ms,
        output ready
    );
endinterface

FILE: hdl/slbg_out_if.sv
interface slbg_out_if
    import slbg_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] lit_mask;
    logic [OUT_W-1:0] red_mask;
    logic [OUT_W-1:0] yellow_mask;
    logic [OUT_W-1:0] green_mask;

    modport source (
        output valid, lit_mask, red_mask, yellow_mask, green_mask,
        input  ready
    );

    modport sink (
        input  valid, lit_mask, red_mask, yellow_mask, green_mask,
        output ready
    );
endinterface

FILE: hdl/slbg_prep.sv
module slbg_prep
    import slbg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  slbg_cfg_t        cfg,
    slbg_in_if.sink          sample,
    output logic             out_valid,
    input  logic             out_ready,
    output slbg_work_t       out_work
);

    logic       valid_reg;
    logic       valid_next;
    slbg_work_t work_reg;
    slbg_work_t work_next;
    logic       load;

    logic [SPEED_W-1:0] diff_c;
    logic [SPEED_W-1:0] diff_r;
    logic [SPEED_W-1:0] range_w;
    logic               order_ok;

    assign sample.ready = !valid_reg || out_ready;
    assign load         = sample.valid && sample.ready;

    always_comb
    begin
        diff_c   = sample.engine_speed - cfg.start_threshold;
        diff_r   = cfg.red_threshold - cfg.start_threshold;
        range_w  = cfg.full_threshold - cfg.start_threshold;
        order_ok = (cfg.start_threshold < cfg.red_threshold) &&
                   (cfg.red_threshold < cfg.flash_threshold) &&
                   (cfg.flash_threshold <= cfg.full_threshold);

        work_next.active  = sample.speed_valid && order_ok;
        work_next.flash   = cfg.flash_enable &&
                            (sample.engine_speed >= cfg.flash_threshold);
        work_next.at_full = sample.engine_speed >= cfg.full_threshold;
        work_next.below   = sample.engine_speed < cfg.start_threshold;
        work_next.rem_c   = DIV_W'(diff_c) * DIV_W'(SEGMENT_COUNT);
        work_next.rem_r   = DIV_W'(diff_r) * DIV_W'(SEGMENT_COUNT);
        work_next.divisor = DIV_W'(range_w) << (QUO_W - 1);
        work_next.q_c     = '0;
        work_next.q_r     = '0;
        // byte-wise fold: 2^8k taken mod 250
        work_next.t_res   = TRES_W'(sample.time_ms[31:24]) * TRES_W'(POW24_MOD) +
                            TRES_W'(sample.time_ms[23:16]) * TRES_W'(POW16_MOD) +
                            TRES_W'(sample.time_ms[15:8])  * TRES_W'(POW8_MOD) +
                            TRES_W'(sample.time_ms[7:0]);

        valid_next = sample.ready ? sample.valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

FILE: hdl/slbg_div_cell.sv
module slbg_div_cell
    import slbg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  slbg_work_t in_work,
    output logic       out_valid,
    input  logic       out_ready,
    output slbg_work_t out_work
);

    logic       valid_reg;
    logic       valid_next;
    slbg_work_t work_reg;
    slbg_work_t work_next;
    logic       take_c;
    logic       take_r;

    assign in_ready = !valid_reg || out_ready;

    // one restoring step for both dividers, divisor halves on the way out
    always_comb
    begin
        take_c = in_work.rem_c >= in_work.divisor;
        take_r = in_work.rem_r >= in_work.divisor;

        work_next         = in_work;
        work_next.rem_c   = take_c ? in_work.rem_c - in_work.divisor : in_work.rem_c;
        work_next.rem_r   = take_r ? in_work.rem_r - in_work.divisor : in_work.rem_r;
        work_next.divisor = in_work.divisor >> 1;
        work_next.q_c     = QUO_W'({in_work.q_c, take_c});
        work_next.q_r     = QUO_W'({in_work.q_r, take_r});

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

FILE: hdl/slbg_out_stage.sv
module slbg_out_stage
    import slbg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  slbg_work_t in_work,
    slbg_out_if.source result
);

    logic             valid_reg;
    logic             valid_next;
    logic [OUT_W-1:0] lit_reg;
    logic [OUT_W-1:0] red_reg;
    logic [OUT_W-1:0] yellow_reg;
    logic [OUT_W-1:0] green_reg;
    logic [OUT_W-1:0] lit_next;
    logic [OUT_W-1:0] red_next;
    logic [OUT_W-1:0] yellow_next;
    logic [OUT_W-1:0] green_next;

    logic [FOLD2_W-1:0] fold2;
    logic [FOLD3_W-1:0] fold3;
    logic               phase_even;
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   red_idx;
    logic [CNT_W-1:0]   yel_idx;
    logic [CNT_W-1:0]   seg;
    logic               exists;

    assign in_ready = !valid_reg || result.ready;

    always_comb
    begin
        // finish the mod 250 reduction; even phase when residue < 125
        fold2 = FOLD2_W'(in_work.t_res[16:8]) * FOLD2_W'(POW8_MOD) +
                FOLD2_W'(in_work.t_res[7:0]);
        fold3 = FOLD3_W'(fold2[10:8]) * FOLD3_W'(POW8_MOD) +
                FOLD3_W'(fold2[7:0]);
        phase_even = (fold3 < FOLD3_W'(PHASE_MS)) || (fold3 >= FOLD3_W'(PHASE_PERIOD));

        if (in_work.below)
        begin
            count = '0;
        end
        else if (in_work.at_full)
        begin
            count = CNT_W'(SEGMENT_COUNT);
        end
        else
        begin
            count = CNT_W'(in_work.q_c) + CNT_W'(1);
        end

        red_idx = CNT_W'(in_work.q_r);
        yel_idx = (red_idx > CNT_W'(1)) ? red_idx - CNT_W'(2) : '0;

        lit_next    = '0;
        red_next    = '0;
        yellow_next = '0;
        green_next  = '0;
        seg         = '0;
        exists      = 1'b0;

        for (int i = 0; i < OUT_W; i++)
        begin
            exists = i < SEGMENT_COUNT;
            seg    = exists ? CNT_W'(i) : '0;
            if (!in_work.active || !exists)
            begin
                lit_next[i] = 1'b0;
            end
            else if (in_work.flash)
            begin
                lit_next[i] = phase_even;
                red_next[i] = phase_even;
            end
            else if (seg < count)
            begin
                lit_next[i] = 1'b1;
                if (seg >= red_idx)
                begin
                    red_next[i] = 1'b1;
                end
                else if (seg >= yel_idx)
                begin
                    yellow_next[i] = 1'b1;
                end
                else
                begin
                    green_next[i] = 1'b1;
                end
            end
        end

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            lit_reg    <= lit_next;
            red_reg    <= red_next;
            yellow_reg <= yellow_next;
            green_reg  <= green_next;
        end
    end

    assign result.valid       = valid_reg;
    assign result.lit_mask    = lit_reg;
    assign result.red_mask    = red_reg;
    assign result.yellow_mask = yellow_reg;
    assign result.green_mask  = green_reg;

    // colours split the lit bar exactly
    a_colours_cover_lit: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((red_reg | yellow_reg | green_reg) == lit_reg))
        else $error("colour masks do not match lit mask");

    a_colours_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (((red_reg & yellow_reg) == '0) &&
                       ((red_reg & green_reg) == '0) &&
                       ((yellow_reg & green_reg) == '0)))
        else $error("segment has more than one colour");

    a_bar_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((OUT_W'(lit_reg + OUT_W'(1)) & lit_reg) == '0))
        else $error("lit bar has a gap");

endmodule

FILE: hdl/shift_light_bar_graph_top.sv
// Channel   Port      Direction  Payload
// -------   ------    ---------  ----------------------------------------------
// sample    sample    sink       engine_speed[15:0], speed_valid, time_ms[31:0]
// result    result    source     lit_mask, red_mask, yellow_mask, green_mask [11:0]
// config    cfg_*     write      cfg_index[2:0], cfg_data[15:0]
//
// One request per cycle sustained while the result side keeps ready high; the path is registered in
// a front stage, one divider cell per quotient bit, and the output register.
// Each cell resolves one quotient bit of both the bar count and the red index.
// Stages have their own valid bits, so bubbles close up while the output stalls.
// rst_n clears valid bits and thresholds; payload registers are not reset.
module shift_light_bar_graph_top
    import slbg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    slbg_in_if.sink               sample,
    slbg_out_if.source            result
);

    slbg_cfg_t cfg_reg;
    slbg_cfg_t cfg_next;

    logic       stage_valid [QUO_W+1];
    logic       stage_ready [QUO_W+1];
    slbg_work_t stage_work  [QUO_W+1];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_START_THRESHOLD: cfg_next.start_threshold = cfg_data;
                REG_RED_THRESHOLD:   cfg_next.red_threshold   = cfg_data;
                REG_FLASH_THRESHOLD: cfg_next.flash_threshold = cfg_data;
                REG_FULL_THRESHOLD:  cfg_next.full_threshold  = cfg_data;
                REG_FLASH_ENABLE:    cfg_next.flash_enable    = cfg_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    slbg_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .sample    (sample),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_work  (stage_work[0])
    );

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_cell
        slbg_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[k]),
            .in_ready  (stage_ready[k]),
            .in_work   (stage_work[k]),
            .out_valid (stage_valid[k+1]),
            .out_ready (stage_ready[k+1]),
            .out_work  (stage_work[k+1])
        );
    end

    slbg_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stage_valid[QUO_W]),
        .in_ready (stage_ready[QUO_W]),
        .in_work  (stage_work[QUO_W]),
        .result   (result)
    );

endmodule

FILE: tb/shift_light_bar_graph_top_tb.sv
module shift_light_bar_graph_top_tb
    import slbg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 950;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT = 400_000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_FLASH_ENABLE + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST = '1;

    typedef struct packed {
        logic [OUT_W-1:0] lit;
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] yellow;
        logic [OUT_W-1:0] green;
    } bar_masks_t;

    class bar_graph_scoreboard;
        int unsigned start_thr;
        int unsigned red_thr;
        int unsigned flash_thr;
        int unsigned full_thr;
        bit          flash_on;
        bar_masks_t  expected_q[$];
        int          errors;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_START_THRESHOLD: start_thr = 32'(value);
                REG_RED_THRESHOLD:   red_thr = 32'(value);
                REG_FLASH_THRESHOLD: flash_thr = 32'(value);
                REG_FULL_THRESHOLD:  full_thr = 32'(value);
                REG_FLASH_ENABLE:    flash_on = value[0];
                default: ;
            endcase
        endfunction

        function bar_masks_t predict_masks(logic [SPEED_W-1:0] speed, logic ok,
                                           logic [TIME_W-1:0] t);
            bar_masks_t  m;
            int unsigned spd;
            int unsigned tt;
            int unsigned span;
            int unsigned count;
            int unsigned red_idx;
            int unsigned yel_idx;
            m = '0;
            spd = 32'(speed);
            tt = t;
            if (!ok || !(start_thr < red_thr && red_thr < flash_thr && flash_thr <= full_thr))
                return m;
            if (flash_on && spd >= flash_thr)
            begin
                // even phases light the whole bar red, odd phases are dark
                if (((tt / PHASE_MS) % 2) == 0)
                begin
                    for (int i = 0; i < OUT_W; i++)
                    begin
                        if (i < SEGMENT_COUNT)
                        begin
                            m.lit[i] = 1'b1;
                            m.red[i] = 1'b1;
                        end
                    end
                end
                return m;
            end
            span = full_thr - start_thr;
            count = 0;
            if (spd >= full_thr)
                count = SEGMENT_COUNT;
            else if (spd >= start_thr)
            begin
                count = 1 + ((spd - start_thr) * SEGMENT_COUNT) / span;
                if (count > SEGMENT_COUNT)
                    count = SEGMENT_COUNT;
            end
            red_idx = ((red_thr - start_thr) * SEGMENT_COUNT) / span;
            if (red_idx > SEGMENT_COUNT - 1)
                red_idx = SEGMENT_COUNT - 1;
            yel_idx = (red_idx > 1) ? red_idx - 2 : 0;
            for (int i = 0; i < OUT_W; i++)
            begin
                if (i < count)
                begin
                    m.lit[i] = 1'b1;
                    if (i >= red_idx)
                        m.red[i] = 1'b1;
                    else if (i >= yel_idx)
                        m.yellow[i] = 1'b1;
                    else
                        m.green[i] = 1'b1;
                end
            end
            return m;
        endfunction

        function void note_sample(logic [SPEED_W-1:0] speed, logic ok, logic [TIME_W-1:0] t);
            expected_q.push_back(predict_masks(speed, ok, t));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_result(bar_masks_t got);
            bar_masks_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result lit=%03h red=%03h", got.lit,
                                          got.red));
                return;
            end
            want = expected_q.pop_front();
            if (got.lit !== want.lit)
                report_mismatch($sformatf("lit_mask %03h, want %03h", got.lit, want.lit));
            if (got.red !== want.red)
                report_mismatch($sformatf("red_mask %03h, want %03h", got.red, want.red));
            if (got.yellow !== want.yellow)
                report_mismatch($sformatf("yellow_mask %03h, want %03h", got.yellow,
                                          want.yellow));
            if (got.green !== want.green)
                report_mismatch($sformatf("green_mask %03h, want %03h", got.green,
                                          want.green));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    slbg_in_if  sample_ch ();
    slbg_out_if result_ch ();

    shift_light_bar_graph_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    bar_graph_scoreboard sb = new;

    bit tx_idle;
    bit rx_idle;
    int hold_requests;
    int items_sent;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SPEED_W-1:0] clamp_speed(int v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return '1;
        return v[SPEED_W-1:0];
    endfunction

    function automatic logic [SPEED_W-1:0] pick_speed();
        int r;
        int thr;
        r = $urandom_range(0, 9);
        if (r < 3)
            return SPEED_W'($urandom_range(0, 65535));
        // window around the bar only when the span is not inverted
        if (r < 7 && sb.full_thr >= sb.start_thr)
            return clamp_speed(int'($urandom_range(0, 65535) %
                                    (sb.full_thr - sb.start_thr + 201))
                               + int'(sb.start_thr) - 100);
        case ($urandom_range(0, 3))
            0: thr = sb.start_thr;
            1: thr = sb.red_thr;
            2: thr = sb.flash_thr;
            default: thr = sb.full_thr;
        endcase
        return clamp_speed(thr + int'($urandom_range(0, 6)) - 3);
    endfunction

    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1000);
            1: return 125 * $urandom_range(0, 34359737) + $urandom_range(0, 2) + 123;
            default: return $urandom;
        endcase
    endfunction

    // result side: random stalls, plus a long hold-off when asked for
    initial
    begin
        int stall_left;
        int holds_done;
        stall_left = 0;
        holds_done = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                sb.check_result({result_ch.lit_mask, result_ch.red_mask,
                                 result_ch.yellow_mask, result_ch.green_mask});
            if (holds_done != hold_requests)
            begin
                holds_done++;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (rx_idle)
                    stall_left = gap_len();
            end
        end
    end

    task automatic send_sample(input logic [SPEED_W-1:0] speed, input logic ok,
                               input logic [TIME_W-1:0] t);
        int gap;
        sample_ch.valid        <= 1'b1;
        sample_ch.engine_speed <= speed;
        sample_ch.speed_valid  <= ok;
        sample_ch.time_ms      <= t;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        sb.note_sample(speed, ok, t);
        items_sent++;
        gap = tx_idle ? gap_len() : 0;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drop valid and let every outstanding request come back
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    // a stray index and junk above the enable bit must have no effect
    task automatic program_bar(input int unsigned st, input int unsigned rd,
                               input int unsigned fl, input int unsigned fu, input bit fe);
        write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                  CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(REG_START_THRESHOLD, CFG_DATA_W'(st));
        write_reg(REG_RED_THRESHOLD, CFG_DATA_W'(rd));
        write_reg(REG_FLASH_THRESHOLD, CFG_DATA_W'(fl));
        write_reg(REG_FULL_THRESHOLD, CFG_DATA_W'(fu));
        write_reg(REG_FLASH_ENABLE, {15'($urandom_range(0, 32767)), fe});
        cfg_write <= 1'b0;
    endtask

    task automatic program_random();
        int unsigned st;
        int unsigned rd;
        int unsigned fl;
        int unsigned fu;
        int unsigned top;
        if ($urandom_range(0, 4) == 0)
        begin
            // often out of order, which keeps the bar dark
            st = $urandom_range(0, 65535);
            rd = $urandom_range(0, 65535);
            fl = $urandom_range(0, 65535);
            fu = $urandom_range(0, 65535);
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            st = 0;
            fu = 65535;
            rd = $urandom_range(1, 65533);
            fl = $urandom_range(rd + 1, 65535);
        end
        else
        begin
            st = $urandom_range(0, 65533);
            top = ($urandom_range(0, 2) == 0 && st + 40 < 65535) ? st + 40 : 65535;
            fu = $urandom_range(st + 2, top);
            rd = $urandom_range(st + 1, fu - 1);
            fl = $urandom_range(rd + 1, fu);
        end
        program_bar(st, rd, fl, fu, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int phase;
        int burst;
        rst_n                  <= 1'b0;
        cfg_write              <= 1'b0;
        cfg_index              <= '0;
        cfg_data               <= '0;
        sample_ch.valid        <= 1'b0;
        sample_ch.engine_speed <= '0;
        sample_ch.speed_valid  <= 1'b0;
        sample_ch.time_ms      <= '0;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_requests = 0;
        items_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // thresholds all zero after reset: bar stays dark
        send_sample(16'd0, 1'b1, 32'd0);
        send_sample(16'hFFFF, 1'b1, 32'd0);
        drain();

        tx_idle = 1'b1;
        rx_idle = 1'b1;
        program_bar(1000, 5000, 6000, 7000, 1'b1);
        send_sample(16'd0, 1'b1, 32'd0);
        send_sample(16'd999, 1'b1, 32'd0);
        send_sample(16'd1000, 1'b1, 32'd0);
        send_sample(16'd1001, 1'b1, 32'd0);
        send_sample(16'd4999, 1'b1, 32'd0);
        send_sample(16'd5000, 1'b1, 32'd0);
        send_sample(16'd5999, 1'b1, 32'd125);
        send_sample(16'd6000, 1'b1, 32'd0);
        send_sample(16'd6000, 1'b1, 32'd124);
        send_sample(16'd6000, 1'b1, 32'd125);
        send_sample(16'd6999, 1'b1, 32'd249);
        send_sample(16'd7000, 1'b1, 32'd250);
        send_sample(16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        send_sample(16'd3000, 1'b0, 32'd0);
        send_sample(16'hFFFF, 1'b0, 32'd0);
        drain();
        // flash off: the bar tops out instead
        program_bar(1000, 5000, 6000, 7000, 1'b0);
        send_sample(16'd6500, 1'b1, 32'd0);
        send_sample(16'd7000, 1'b1, 32'd0);
        send_sample(16'hFFFF, 1'b1, 32'd0);
        drain();
        // widest span, flash point at the full point
        program_bar(0, 1, 65535, 65535, 1'b1);
        send_sample(16'd0, 1'b1, 32'd0);
        send_sample(16'd1, 1'b1, 32'd0);
        send_sample(16'd65534, 1'b1, 32'd0);
        send_sample(16'hFFFF, 1'b1, 32'd0);
        send_sample(16'hFFFF, 1'b1, 32'd130);
        drain();
        // narrowest span at the top of the range
        program_bar(65532, 65533, 65534, 65535, 1'b0);
        send_sample(16'd65531, 1'b1, 32'd0);
        send_sample(16'd65532, 1'b1, 32'd0);
        send_sample(16'd65533, 1'b1, 32'd0);
        send_sample(16'd65534, 1'b1, 32'd0);
        drain();
        // each ordering rule broken once
        program_bar(5000, 5000, 6000, 7000, 1'b0);
        send_sample(16'd6500, 1'b1, 32'd0);
        drain();
        program_bar(1000, 6000, 6000, 7000, 1'b1);
        send_sample(16'd6500, 1'b1, 32'd0);
        drain();
        program_bar(1000, 5000, 7001, 7000, 1'b1);
        send_sample(16'd7500, 1'b1, 32'd0);
        drain();

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            program_random();
            if (phase == 1)
            begin
                // receiver holds off while samples keep coming
                tx_idle = 1'b0;
                rx_idle = 1'b0;
                hold_requests <= hold_requests + 1;
                burst = 60;
            end
            else
            begin
                tx_idle = $urandom_range(0, 2) != 0;
                rx_idle = $urandom_range(0, 2) != 0;
                burst = $urandom_range(30, 100);
            end
            repeat (burst)
                send_sample(pick_speed(), $urandom_range(0, 9) != 0, pick_time());
            drain();
            phase++;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
